### sv/round_robin_voice_allocator_defines.svh
// assertion macros used by the checker file
`ifndef ROUND_ROBIN_VOICE_ALLOCATOR_DEFINES_SVH
`define ROUND_ROBIN_VOICE_ALLOCATOR_DEFINES_SVH

// same-cycle implication
`define RRVA_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RRVA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/rrva_pkg.sv
`default_nettype none

package rrva_pkg;

    localparam int VOICES_DEFAULT = 16;

    localparam int TIME_W = 32;
    localparam int EXT_W  = TIME_W + 2;
    localparam int HT_W   = 16;
    localparam int VC_W   = 5;
    localparam int VIDX_W = 4;
    localparam int USED_W = 5;
    localparam int KIND_W = 2;

    localparam int IN_TDATA_W  = 64;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 16;
    localparam int OUT_TUSER_W = KIND_W;
    localparam int APB_ADDR_W  = 4;
    localparam int APB_DATA_W  = 32;

    localparam logic [VC_W-1:0] VOICE_COUNT_RESET = VC_W'(16);

    typedef enum logic [1:0] {
        REG_VOICE_COUNT = 2'd0,
        REG_DUR_FROM_ITEM = 2'd1,
        REG_FIXED_DUR = 2'd2,
        REG_GUARD_TIME = 2'd3
    } reg_idx_t;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_COUNT = 1'b1
    } op_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_VOICE    = 2'd0,
        KIND_OVERFLOW = 2'd1,
        KIND_COUNT    = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WRITE,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [VC_W-1:0]   voice_count;
        logic              dur_from_item;
        logic [TIME_W-1:0] fixed_dur;
        logic [HT_W-1:0]   guard_time;
    } cfg_t;

    typedef struct packed {
        op_t               op;
        logic [TIME_W-1:0] now_time;
        logic              has_duration;
        logic [TIME_W-1:0] duration_value;
    } item_t;

    typedef struct packed {
        kind_t             kind;
        logic [VIDX_W-1:0] voice_index;
        logic [USED_W-1:0] used_count;
    } result_t;

    // clamp an exact signed time to the unsigned 32-bit range
    function automatic logic [TIME_W-1:0] clamp_time(input logic signed [EXT_W-1:0] t);
        logic [TIME_W-1:0] r;
        if (t[EXT_W-1])
        begin
            r = '0;
        end
        else if (t[EXT_W-2])
        begin
            r = '1;
        end
        else
        begin
            r = t[TIME_W-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### sv/rrva_expiry_store.sv
`default_nettype none

module rrva_expiry_store #(
    parameter int VOICES = rrva_pkg::VOICES_DEFAULT,
    parameter int IW     = 4
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            rd_en,
    input  wire logic [IW-1:0]                   rd_addr,
    output logic      [rrva_pkg::TIME_W-1:0]     rd_data,
    input  wire logic                            wr_en,
    input  wire logic [IW-1:0]                   wr_addr,
    input  wire logic [rrva_pkg::TIME_W-1:0]     wr_data
);

    logic [rrva_pkg::TIME_W-1:0] expiry_mem_reg [VOICES];
    logic [rrva_pkg::TIME_W-1:0] rd_data_reg;
    logic [VOICES-1:0]           valid_reg;
    logic                        rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            expiry_mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= expiry_mem_reg[rd_addr];
        end
    end

    // an entry never written reads as zero, the reset expiry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

`default_nettype wire

### sv/rrva_seq.sv
`default_nettype none

module rrva_seq #(
    parameter int VOICES = rrva_pkg::VOICES_DEFAULT,
    parameter int IW     = 4,
    parameter int CW     = 5
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire rrva_pkg::cfg_t              cfg,
    input  wire logic                        item_valid,
    output logic                             item_ready,
    input  wire rrva_pkg::item_t             item,
    output logic                             res_valid,
    input  wire logic                        res_take,
    output rrva_pkg::result_t                res,
    output logic                             rd_en,
    output logic [IW-1:0]                    rd_addr,
    input  wire logic [rrva_pkg::TIME_W-1:0] rd_data,
    output logic                             wr_en,
    output logic [IW-1:0]                    wr_addr,
    output logic [rrva_pkg::TIME_W-1:0]      wr_data
);

    localparam int EXT_W  = rrva_pkg::EXT_W;
    localparam int TIME_W = rrva_pkg::TIME_W;
    localparam int HT_W   = rrva_pkg::HT_W;

    rrva_pkg::state_t state_reg, state_next;
    rrva_pkg::op_t    op_reg, op_next;
    rrva_pkg::kind_t  kind_reg, kind_next;

    logic [TIME_W-1:0]       now_reg, now_next;
    logic [TIME_W-1:0]       dur_reg, dur_next;
    logic [TIME_W-1:0]       last_dur_reg, last_dur_next;
    logic signed [EXT_W-1:0] key_reg, key_next;
    logic [CW-1:0]           n_reg, n_next;
    logic [CW-1:0]           iss_reg, iss_next;
    logic [CW-1:0]           chk_reg, chk_next;
    logic [CW-1:0]           used_reg, used_next;
    logic [IW-1:0]           addr_reg, addr_next;
    logic [IW-1:0]           pidx_reg, pidx_next;
    logic [IW-1:0]           hit_reg, hit_next;
    logic [IW-1:0]           next_voice_reg, next_voice_next;
    logic                    pend_reg, pend_next;

    logic [CW-1:0]           n_eff;
    logic [IW-1:0]           start_idx;
    logic signed [EXT_W-1:0] now_ext;
    logic signed [EXT_W-1:0] thr;
    logic signed [EXT_W-1:0] expiry_sum;
    logic [CW-1:0]           chk_inc;
    logic                    greater;

    function automatic logic [IW-1:0] wrap_inc(input logic [IW-1:0] a, input logic [CW-1:0] n);
        logic [CW-1:0] s;
        s = CW'(a) + CW'(1);
        return (s >= n) ? '0 : IW'(s);
    endfunction

    // voice_count of zero acts as one, above the built depth as the depth
    always_comb
    begin
        if (cfg.voice_count == '0)
        begin
            n_eff = CW'(1);
        end
        else if (32'(cfg.voice_count) > 32'(VOICES))
        begin
            n_eff = CW'(VOICES);
        end
        else
        begin
            n_eff = CW'(cfg.voice_count);
        end
    end

    assign start_idx = (CW'(next_voice_reg) >= n_eff) ? '0 : next_voice_reg;
    assign now_ext   = $signed({{(EXT_W-TIME_W){1'b0}}, item.now_time});
    assign thr       = now_ext - $signed({{(EXT_W-HT_W-1){1'b0}}, cfg.guard_time, 1'b0});
    assign expiry_sum = $signed({{(EXT_W-TIME_W){1'b0}}, now_reg})
                      + $signed({{(EXT_W-TIME_W){1'b0}}, dur_reg})
                      - $signed({{(EXT_W-HT_W){1'b0}}, cfg.guard_time});
    assign chk_inc   = chk_reg + CW'(1);

    // the one shared compare: expiry after the key
    assign greater = $signed({{(EXT_W-TIME_W){1'b0}}, rd_data}) > key_reg;

    assign rd_addr = addr_reg;
    assign wr_addr = hit_reg;
    assign wr_data = rrva_pkg::clamp_time(expiry_sum);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= rrva_pkg::ST_IDLE;
            next_voice_reg <= '0;
            last_dur_reg   <= '0;
            pend_reg       <= 1'b0;
            iss_reg        <= '0;
            chk_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            next_voice_reg <= next_voice_next;
            last_dur_reg   <= last_dur_next;
            pend_reg       <= pend_next;
            iss_reg        <= iss_next;
            chk_reg        <= chk_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        kind_reg <= kind_next;
        now_reg  <= now_next;
        dur_reg  <= dur_next;
        key_reg  <= key_next;
        n_reg    <= n_next;
        used_reg <= used_next;
        addr_reg <= addr_next;
        pidx_reg <= pidx_next;
        hit_reg  <= hit_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        kind_next       = kind_reg;
        now_next        = now_reg;
        dur_next        = dur_reg;
        last_dur_next   = last_dur_reg;
        key_next        = key_reg;
        n_next          = n_reg;
        iss_next        = iss_reg;
        chk_next        = chk_reg;
        used_next       = used_reg;
        addr_next       = addr_reg;
        pidx_next       = pidx_reg;
        hit_next        = hit_reg;
        next_voice_next = next_voice_reg;
        pend_next       = pend_reg;
        item_ready      = 1'b0;
        res_valid       = 1'b0;
        rd_en           = 1'b0;
        wr_en           = 1'b0;

        case (state_reg)
            rrva_pkg::ST_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    op_next         = item.op;
                    now_next        = item.now_time;
                    n_next          = n_eff;
                    next_voice_next = start_idx;
                    iss_next        = '0;
                    chk_next        = '0;
                    used_next       = '0;
                    pend_next       = 1'b0;
                    state_next      = rrva_pkg::ST_SCAN;
                    if (item.op == rrva_pkg::OP_COUNT)
                    begin
                        key_next  = thr;
                        addr_next = '0;
                    end
                    else
                    begin
                        key_next  = now_ext;
                        addr_next = start_idx;
                        if (cfg.dur_from_item)
                        begin
                            dur_next      = item.has_duration ? item.duration_value : last_dur_reg;
                            last_dur_next = dur_next;
                        end
                        else
                        begin
                            dur_next = cfg.fixed_dur;
                        end
                    end
                end
            end

            rrva_pkg::ST_SCAN:
            begin
                // one read issued per cycle, checked in the cycle after
                pend_next = 1'b0;
                if (iss_reg != n_reg)
                begin
                    rd_en     = 1'b1;
                    pidx_next = addr_reg;
                    addr_next = wrap_inc(addr_reg, n_reg);
                    iss_next  = iss_reg + CW'(1);
                    pend_next = 1'b1;
                end
                if (pend_reg)
                begin
                    if (op_reg == rrva_pkg::OP_ALLOC && !greater)
                    begin
                        hit_next   = pidx_reg;
                        state_next = rrva_pkg::ST_WRITE;
                    end
                    else
                    begin
                        if (op_reg == rrva_pkg::OP_COUNT && greater)
                        begin
                            used_next = used_reg + CW'(1);
                        end
                        chk_next = chk_inc;
                        if (chk_inc == n_reg)
                        begin
                            kind_next  = (op_reg == rrva_pkg::OP_COUNT) ?
                                         rrva_pkg::KIND_COUNT : rrva_pkg::KIND_OVERFLOW;
                            state_next = rrva_pkg::ST_DONE;
                        end
                    end
                end
            end

            rrva_pkg::ST_WRITE:
            begin
                wr_en           = 1'b1;
                kind_next       = rrva_pkg::KIND_VOICE;
                next_voice_next = wrap_inc(hit_reg, n_reg);
                state_next      = rrva_pkg::ST_DONE;
            end

            rrva_pkg::ST_DONE:
            begin
                res_valid = 1'b1;
                if (res_take)
                begin
                    state_next = rrva_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = rrva_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        res.kind        = kind_reg;
        res.voice_index = (kind_reg == rrva_pkg::KIND_VOICE) ? rrva_pkg::VIDX_W'(hit_reg) : '0;
        res.used_count  = (kind_reg == rrva_pkg::KIND_COUNT) ? rrva_pkg::USED_W'(used_reg) : '0;
    end

endmodule

`default_nettype wire

### sv/round_robin_voice_allocator.sv
// flow: an item is taken in idle, scanned, written (allocate with a free voice only) and
// held in done until the output register takes its result beat
// throughput: one item in work at a time; the scan is bound by the
// expiry memory's single read port, which the scan walks one voice per cycle
// reset: asynchronous active low; all expiries read as zero, pointer and last duration
// clear, voice_count returns to 16 and the other registers to zero
`default_nettype none

module round_robin_voice_allocator #(
    parameter int VOICES = rrva_pkg::VOICES_DEFAULT
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    // stream in
    input  wire logic                                 s_axis_tvalid,
    output logic                                      s_axis_tready,
    input  wire logic [rrva_pkg::IN_TDATA_W-1:0]      s_axis_tdata,  // now_time, duration_value
    input  wire logic [rrva_pkg::IN_TUSER_W-1:0]      s_axis_tuser,  // op, has_duration
    // stream out
    output logic                                      m_axis_tvalid,
    input  wire logic                                 m_axis_tready,
    output logic      [rrva_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,  // voice_index, used_count
    output logic      [rrva_pkg::OUT_TUSER_W-1:0]     m_axis_tuser,  // result_kind
    // register port
    input  wire logic                                 psel,
    input  wire logic                                 penable,
    input  wire logic                                 pwrite,
    input  wire logic [rrva_pkg::APB_ADDR_W-1:0]      paddr,
    input  wire logic [rrva_pkg::APB_DATA_W-1:0]      pwdata,
    output logic      [rrva_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                      pready
);

    localparam int IW = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int CW = $clog2(VOICES + 1);

    logic [rrva_pkg::VC_W-1:0]   vc_reg;
    logic                        dfi_reg;
    logic [rrva_pkg::TIME_W-1:0] fixed_dur_reg;
    logic [rrva_pkg::HT_W-1:0]   guard_time_reg;
    logic                        cfg_wr;
    rrva_pkg::reg_idx_t          reg_idx;
    rrva_pkg::cfg_t              cfg;
    rrva_pkg::item_t             item;
    rrva_pkg::result_t           res;
    logic                        res_valid;
    logic                        res_take;

    logic                             rd_en;
    logic [IW-1:0]                    rd_addr;
    logic [rrva_pkg::TIME_W-1:0]      rd_data;
    logic                             wr_en;
    logic [IW-1:0]                    wr_addr;
    logic [rrva_pkg::TIME_W-1:0]      wr_data;

    logic                             m_valid_reg;
    logic [rrva_pkg::OUT_TDATA_W-1:0] m_data_reg;
    logic [rrva_pkg::OUT_TUSER_W-1:0] m_user_reg;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = rrva_pkg::reg_idx_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vc_reg         <= rrva_pkg::VOICE_COUNT_RESET;
            dfi_reg        <= 1'b0;
            fixed_dur_reg  <= '0;
            guard_time_reg <= '0;
        end
        else if (cfg_wr)
        begin
            case (reg_idx)
                rrva_pkg::REG_VOICE_COUNT:   vc_reg         <= pwdata[rrva_pkg::VC_W-1:0];
                rrva_pkg::REG_DUR_FROM_ITEM: dfi_reg        <= pwdata[0];
                rrva_pkg::REG_FIXED_DUR:     fixed_dur_reg  <= pwdata[rrva_pkg::TIME_W-1:0];
                rrva_pkg::REG_GUARD_TIME:    guard_time_reg <= pwdata[rrva_pkg::HT_W-1:0];
                default:                     vc_reg         <= vc_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            rrva_pkg::REG_VOICE_COUNT:   prdata = rrva_pkg::APB_DATA_W'(vc_reg);
            rrva_pkg::REG_DUR_FROM_ITEM: prdata = rrva_pkg::APB_DATA_W'(dfi_reg);
            rrva_pkg::REG_FIXED_DUR:     prdata = rrva_pkg::APB_DATA_W'(fixed_dur_reg);
            rrva_pkg::REG_GUARD_TIME:    prdata = rrva_pkg::APB_DATA_W'(guard_time_reg);
            default:                     prdata = '0;
        endcase
    end

    assign cfg.voice_count   = vc_reg;
    assign cfg.dur_from_item = dfi_reg;
    assign cfg.fixed_dur     = fixed_dur_reg;
    assign cfg.guard_time    = guard_time_reg;

    assign item.op             = rrva_pkg::op_t'(s_axis_tuser[0]);
    assign item.has_duration   = s_axis_tuser[1];
    assign item.now_time       = s_axis_tdata[31:0];
    assign item.duration_value = s_axis_tdata[63:32];

    rrva_seq #(
        .VOICES (VOICES),
        .IW     (IW),
        .CW     (CW)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .item_valid (s_axis_tvalid),
        .item_ready (s_axis_tready),
        .item       (item),
        .res_valid  (res_valid),
        .res_take   (res_take),
        .res        (res),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .rd_data    (rd_data),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data)
    );

    rrva_expiry_store #(
        .VOICES (VOICES),
        .IW     (IW)
    ) u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    // output register lets the next item in while a result beat waits
    assign res_take = !m_valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (res_valid && res_take)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_take)
        begin
            m_data_reg <= rrva_pkg::OUT_TDATA_W'({res.used_count, res.voice_index});
            m_user_reg <= res.kind;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;

endmodule

`default_nettype wire

### sv/rrva_checker.sv
`default_nettype none
`include "round_robin_voice_allocator_defines.svh"

module rrva_checker (
    input wire logic                                 clk,
    input wire logic                                 rst_n,
    input wire logic                                 s_axis_tvalid,
    input wire logic                                 s_axis_tready,
    input wire logic                                 m_axis_tvalid,
    input wire logic                                 m_axis_tready,
    input wire logic [rrva_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    input wire logic [rrva_pkg::OUT_TUSER_W-1:0]     m_axis_tuser
);

    `RRVA_ASSERT_NEXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result beat changed while stalled")

    // one item at a time: busy right after taking a beat
    `RRVA_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input taken again while an item is in work")

    `RRVA_ASSERT_IMPL(a_overflow_empty, clk, rst_n, m_axis_tvalid && (m_axis_tuser == rrva_pkg::KIND_OVERFLOW), m_axis_tdata == '0, "overflow beat carries voice or count")

    `RRVA_ASSERT_IMPL(a_count_no_voice, clk, rst_n, m_axis_tvalid && (m_axis_tuser == rrva_pkg::KIND_COUNT), m_axis_tdata[3:0] == '0, "count beat carries a voice index")

endmodule

bind round_robin_voice_allocator rrva_checker u_rrva_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
